// ===== rtl/smad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smad_pkg: shared definitions for the sliding median absolute deviation block
// Widths, window sizing and the control struct of the deviation accumulator.
// ----------------------------------------------------------------------------
package smad_pkg;

  // Window sizing.
  localparam int unsigned WindowMax = 64;
  localparam int unsigned IdxW      = (WindowMax > 1) ? $clog2(WindowMax) : 1;
  localparam int unsigned CntW      = $clog2(WindowMax + 1);

  // Field widths.
  localparam int unsigned SampleW = 32;
  localparam int unsigned CostW   = 38;
  localparam int unsigned WlenW   = 7;

  // Reset value of the window length register.
  localparam logic [WlenW-1:0] WlenReset = 7'd64;

  // Control of the deviation accumulator.
  typedef struct packed {
    logic clr;
    logic en;
  } acc_ctl_t;

endpackage

// ===== rtl/smad_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smad_if: channel interfaces
// Valid/ready channels for samples, costs and the window length register.
// ----------------------------------------------------------------------------

// Sample channel.
interface smad_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [smad_pkg::SampleW-1:0] sample;
  logic                                start_of_stream;

  modport source (output valid, output sample, output start_of_stream, input ready);
  modport sink   (input valid, input sample, input start_of_stream, output ready);
endinterface

// Cost channel.
interface smad_cost_if;
  logic                              valid;
  logic                              ready;
  logic [smad_pkg::CostW-1:0]        cost;

  modport source (output valid, output cost, input ready);
  modport sink   (input valid, input cost, output ready);
endinterface

// Window length write channel.
interface smad_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [smad_pkg::WlenW-1:0]        window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

// ===== rtl/smad_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smad_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smad_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/smad_dev_acc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smad_dev_acc: absolute deviation accumulator
// Adds |sample - median| to a running sum, one sorted entry per cycle while enabled.
// ----------------------------------------------------------------------------
module smad_dev_acc (
  input  logic                                clk_i,
  input  smad_pkg::acc_ctl_t                  ctl_i,
  input  logic signed [smad_pkg::SampleW-1:0] sample_i,
  input  logic signed [smad_pkg::SampleW-1:0] median_i,
  output logic        [smad_pkg::CostW-1:0]   sum_o
);

  logic signed [smad_pkg::SampleW:0]   diff;
  logic signed [smad_pkg::SampleW:0]   neg;
  logic        [smad_pkg::SampleW-1:0] mag;
  logic        [smad_pkg::CostW-1:0]   sum_q;
  logic        [smad_pkg::CostW-1:0]   sum_d;

  // The difference of two 32-bit values needs 33 bits; its magnitude fits in 32.
  always_comb begin
    diff = {sample_i[smad_pkg::SampleW-1], sample_i} - {median_i[smad_pkg::SampleW-1], median_i};
    neg  = -diff;
    mag  = diff[smad_pkg::SampleW] ? neg[smad_pkg::SampleW-1:0] : diff[smad_pkg::SampleW-1:0];
    sum_d = sum_q + smad_pkg::CostW'(mag);
  end

  // Running sum.
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      sum_q <= '0;
    end else if (ctl_i.en) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/sliding_median_abs_deviation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_median_abs_deviation: sliding window median absolute deviation sum
// Keeps the last k samples in a ring and in a sorted store, and for each
// sample on a full window returns the sum of |x - lower median|.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Payload                           Transaction
//  sample_i   in         sample[31:0], start_of_stream     one sample
//  cost_o     out        cost[37:0]                        one result
//  cfg_i      in         window_length[6:0]                register write
//
// A sample on a full window of k samples keeps the block busy after its
// transaction for one ring read, a merge pass over the old sorted bank into
// the other bank (each old entry in turn, a step for the insert unless it
// sorts to the end, and a closing step), then a read pass over the new
// bank through the shared deviation accumulator and a step to load the
// result. The single read port of the sorted store sets the pass lengths.
// While a sample is in work, sample_i and cfg_i are not ready, and the result
// step waits while the output register still holds a result not yet taken.
// Reset empties the window and sets the window length to 64; no clearing pass.
// ----------------------------------------------------------------------------
module sliding_median_abs_deviation (
  input  logic              clk_i,
  input  logic              rst_ni,
  smad_sample_if.sink       sample_i,
  smad_cost_if.source       cost_o,
  smad_cfg_if.sink          cfg_i
);

  localparam int unsigned IdxW = smad_pkg::IdxW;
  localparam int unsigned CntW = smad_pkg::CntW;
  localparam int unsigned SW   = smad_pkg::SampleW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OLD,
    S_MERGE,
    S_SUM,
    S_EMIT
  } state_e;

  // Control state.
  state_e                       state_q, state_d;
  logic [smad_pkg::WlenW-1:0]   wlen_q, wlen_d;
  logic [CntW-1:0]              fill_q, fill_d;
  logic [IdxW-1:0]              ptr_q, ptr_d;
  logic                         bank_q, bank_d;
  logic                         rm_q, rm_d;
  logic                         removed_q, removed_d;
  logic                         ins_q, ins_d;
  logic                         dv_q, dv_d;
  logic [CntW-1:0]              rd_q, rd_d;
  logic [CntW-1:0]              wr_q, wr_d;
  logic [CntW-1:0]              n_q, n_d;
  logic                         out_valid_q, out_valid_d;
  logic [smad_pkg::CostW-1:0]   cost_q, cost_d;

  // Payload state.
  logic signed [SW-1:0]         x_q, x_d;
  logic signed [SW-1:0]         old_q, old_d;
  logic signed [SW-1:0]         med_q, med_d;
  logic [IdxW-1:0]              slot_q, slot_d;

  // Memory ports.
  logic                         ring_we, ring_re;
  logic [IdxW-1:0]              ring_waddr, ring_raddr;
  logic [SW-1:0]                ring_rdata;
  logic                         sort_we, sort_re;
  logic [IdxW:0]                sort_waddr, sort_raddr;
  logic [SW-1:0]                sort_wdata, sort_rdata;

  // Accumulator.
  smad_pkg::acc_ctl_t           acc_ctl;
  logic [smad_pkg::CostW-1:0]   acc_sum;

  // Combinational helpers.
  logic [CntW-1:0]              keff;
  logic [CntW-1:0]              med_idx;
  logic [CntW:0]                keff_p1;
  logic signed [SW-1:0]         elem;
  logic [CntW-1:0]              fill0;
  logic [IdxW-1:0]              slot0;
  logic [CntW-1:0]              fill_new;
  logic                         adv;
  logic                         cfg_fire, in_fire;

  // Effective window length and lower median rank.
  always_comb begin
    if (wlen_q == '0) begin
      keff = CntW'(1);
    end else if (32'(wlen_q) > smad_pkg::WindowMax) begin
      keff = CntW'(smad_pkg::WindowMax);
    end else begin
      keff = CntW'(wlen_q);
    end
    keff_p1 = {1'b0, keff} + (CntW + 1)'(1);
    med_idx = keff_p1[CntW:1] - CntW'(1);
  end

  assign cfg_i.ready    = (state_q == S_IDLE);
  assign sample_i.ready = (state_q == S_IDLE) && !cfg_i.valid;
  assign cfg_fire       = cfg_i.valid && cfg_i.ready;
  assign in_fire        = sample_i.valid && sample_i.ready;
  assign elem           = $signed(sort_rdata);

  assign cost_o.valid = out_valid_q;
  assign cost_o.cost  = cost_q;

  // Sequencer next-state logic.
  always_comb begin
    state_d     = state_q;
    wlen_d      = wlen_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    bank_d      = bank_q;
    rm_d        = rm_q;
    removed_d   = removed_q;
    ins_d       = ins_q;
    dv_d        = dv_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    n_d         = n_q;
    out_valid_d = out_valid_q;
    cost_d      = cost_q;
    x_d         = x_q;
    old_d       = old_q;
    med_d       = med_q;
    slot_d      = slot_q;

    ring_we    = 1'b0;
    ring_re    = 1'b0;
    ring_waddr = slot_q;
    ring_raddr = slot_q;
    sort_we    = 1'b0;
    sort_re    = 1'b0;
    sort_waddr = {~bank_q, wr_q[IdxW-1:0]};
    sort_wdata = x_q;
    sort_raddr = {bank_q, rd_q[IdxW-1:0]};
    acc_ctl    = '0;

    fill0    = '0;
    slot0    = '0;
    fill_new = wr_q;
    adv      = 1'b0;

    // The output register empties on its transaction.
    if (cost_o.valid && cost_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cfg_fire) begin
          // A length write empties the window.
          wlen_d = cfg_i.window_length;
          fill_d = '0;
          ptr_d  = '0;
        end else if (in_fire) begin
          fill0 = sample_i.start_of_stream ? '0 : fill_q;
          slot0 = (sample_i.start_of_stream || (CntW'(ptr_q) >= keff)) ? '0 : ptr_q;
          slot_d = slot0;
          x_d    = sample_i.sample;
          fill_d = fill0;
          n_d    = fill0;
          rm_d   = (fill0 >= keff);
          ptr_d  = ((CntW'(slot0) + CntW'(1)) >= keff) ? '0 : slot0 + IdxW'(1);
          // Fetch the sample that leaves the window.
          ring_re    = 1'b1;
          ring_raddr = slot0;
          state_d    = S_OLD;
        end
      end

      S_OLD: begin
        old_d      = $signed(ring_rdata);
        ring_we    = 1'b1;
        ring_waddr = slot_q;
        removed_d  = 1'b0;
        ins_d      = 1'b0;
        wr_d       = '0;
        if (n_q != '0) begin
          sort_re    = 1'b1;
          sort_raddr = {bank_q, {IdxW{1'b0}}};
          rd_d       = CntW'(1);
          dv_d       = 1'b1;
        end else begin
          rd_d = '0;
          dv_d = 1'b0;
        end
        state_d = S_MERGE;
      end

      S_MERGE: begin
        if (dv_q) begin
          if (rm_q && !removed_q && (elem == old_q)) begin
            // First entry equal to the leaving sample is dropped.
            removed_d = 1'b1;
            adv       = 1'b1;
          end else if (!ins_q && (elem > x_q)) begin
            // New sample goes in ahead of the first larger entry.
            sort_we    = 1'b1;
            sort_wdata = x_q;
            wr_d       = wr_q + CntW'(1);
            ins_d      = 1'b1;
          end else begin
            sort_we    = 1'b1;
            sort_wdata = sort_rdata;
            wr_d       = wr_q + CntW'(1);
            adv        = 1'b1;
          end
          if (adv) begin
            if (rd_q < n_q) begin
              sort_re = 1'b1;
              rd_d    = rd_q + CntW'(1);
              dv_d    = 1'b1;
            end else begin
              dv_d = 1'b0;
            end
          end
        end else begin
          // Old bank drained: place the sample at the end if still pending.
          if (!ins_q) begin
            sort_we    = 1'b1;
            sort_wdata = x_q;
            fill_new   = wr_q + CntW'(1);
          end
          fill_d = fill_new;
          bank_d = ~bank_q;
          if (fill_new >= keff) begin
            rd_d        = '0;
            dv_d        = 1'b0;
            acc_ctl.clr = 1'b1;
            state_d     = S_SUM;
          end else begin
            state_d = S_IDLE;
          end
        end
        // The lower median is caught as it is written.
        if (sort_we && (wr_q == med_idx)) begin
          med_d = $signed(sort_wdata);
        end
      end

      S_SUM: begin
        acc_ctl.en = dv_q;
        if (rd_q < keff) begin
          sort_re = 1'b1;
          rd_d    = rd_q + CntW'(1);
          dv_d    = 1'b1;
        end else begin
          dv_d = 1'b0;
        end
        if (!dv_q && (rd_q >= keff)) begin
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || cost_o.ready) begin
          out_valid_d = 1'b1;
          cost_d      = acc_sum;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wlen_q      <= smad_pkg::WlenReset;
      fill_q      <= '0;
      ptr_q       <= '0;
      bank_q      <= 1'b0;
      rm_q        <= 1'b0;
      removed_q   <= 1'b0;
      ins_q       <= 1'b0;
      dv_q        <= 1'b0;
      rd_q        <= '0;
      wr_q        <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      cost_q      <= '0;
    end else begin
      state_q     <= state_d;
      wlen_q      <= wlen_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      bank_q      <= bank_d;
      rm_q        <= rm_d;
      removed_q   <= removed_d;
      ins_q       <= ins_d;
      dv_q        <= dv_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      cost_q      <= cost_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    old_q  <= old_d;
    med_q  <= med_d;
    slot_q <= slot_d;
  end

  // Samples in arrival order.
  smad_ram #(
    .Width (SW),
    .Depth (smad_pkg::WindowMax)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (x_q),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  // Sorted store, two banks used alternately.
  smad_ram #(
    .Width (SW),
    .Depth (2 * smad_pkg::WindowMax)
  ) u_sorted (
    .clk_i   (clk_i),
    .we_i    (sort_we),
    .waddr_i (sort_waddr),
    .wdata_i (sort_wdata),
    .re_i    (sort_re),
    .raddr_i (sort_raddr),
    .rdata_o (sort_rdata)
  );

  // Shared deviation unit.
  smad_dev_acc u_acc (
    .clk_i    (clk_i),
    .ctl_i    (acc_ctl),
    .sample_i (elem),
    .median_i (med_q),
    .sum_o    (acc_sum)
  );

endmodule
